// ===== src/jsc_pkg.sv =====
// Shared types and constants for the Shift_JIS converter.
`timescale 1ns / 1ps

package jsc_pkg;

    // Control bytes and escape-sequence bytes.
    localparam logic [7:0] BYTE_ESC    = 8'h1b;
    localparam logic [7:0] BYTE_SO     = 8'h0e;
    localparam logic [7:0] BYTE_SI     = 8'h0f;
    localparam logic [7:0] BYTE_SS2    = 8'h8e;
    localparam logic [7:0] BYTE_DOLLAR = 8'h24;
    localparam logic [7:0] BYTE_PAREN  = 8'h28;

    // Configuration register indexes.
    localparam logic CFG_INPUT_CODE = 1'b0;
    localparam logic CFG_TEXT_ONLY  = 1'b1;

    localparam logic [1:0] CODE_EUC = 2'd2;

    // Most bytes one input item can produce.
    localparam int RUN_MAX = 3;

    // Run queue between the classifier and the byte sequencer.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // The bytes produced by one input item.
    typedef struct packed {
        logic [1:0]                cnt;
        logic [RUN_MAX-1:0][7:0]   data;
    } run_t;

endpackage

// ===== src/jsc_front.sv =====
// Front end: configuration, shift state, and conversion of one byte into a run.
`timescale 1ns / 1ps

module jsc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [1:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_in_byte,
    input  logic                s_first_of_text,
    input  logic                q_full,
    output logic                push,
    output jsc_pkg::run_t       push_run
);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_KANJI  = 2'd1,
        MODE_KANA   = 2'd2,
        MODE_SPARE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_ESC      = 3'd1,
        PH_ESC_DOL  = 3'd2,
        PH_ESC_PAR  = 3'd3,
        PH_JIS_HELD = 3'd4,
        PH_EUC_HELD = 3'd5,
        PH_SS2      = 3'd6,
        PH_SJ_HELD  = 3'd7
    } phase_t;

    logic [1:0] input_code_reg;
    logic       text_only_reg;
    mode_t      mode_reg, mode_next, eff_mode;
    phase_t     phase_reg, phase_next, eff_phase;
    logic [7:0] held_reg, held_next, eff_held;

    logic [1:0]                       cnt;
    logic [jsc_pkg::RUN_MAX-1:0][7:0] bytes;
    logic                             idle;
    logic [15:0]                      pair;
    logic                             accept;

    function automatic logic in_jis(input logic [7:0] c);
        return c >= 8'h21 && c <= 8'h7e;
    endfunction

    function automatic logic in_euc(input logic [7:0] c);
        return c >= 8'ha1 && c <= 8'hfe;
    endfunction

    function automatic logic in_kana(input logic [7:0] c);
        return c >= 8'ha0 && c <= 8'hdf;
    endfunction

    function automatic logic sj_lead(input logic [7:0] c);
        return (c >= 8'h81 && c <= 8'h9f) || (c >= 8'he0 && c <= 8'hef);
    endfunction

    function automatic logic sj_trail(input logic [7:0] c);
        return c >= 8'h40 && c <= 8'hfc && c != 8'h7f;
    endfunction

    // JIS row/cell pair to Shift_JIS lead and trail bytes.
    function automatic logic [15:0] jis_pair_convert(input logic [7:0] h, input logic [7:0] l);
        logic [8:0] hs;
        logic [7:0] lo;
        if (h[0]) begin
            lo = (l < 8'h60) ? 8'(l + 8'h1f) : 8'(l + 8'h20);
        end else begin
            lo = 8'(l + 8'h7e);
        end
        hs = (h < 8'h5f) ? ({1'b0, h} + 9'h0e1) : ({1'b0, h} + 9'h161);
        return {hs[8:1], lo};
    endfunction

    assign accept  = s_valid && s_ready;
    assign s_ready = !q_full;

    always_comb begin
        logic passes;
        logic [7:0] c;
        c = s_in_byte;
        eff_mode  = s_first_of_text ? MODE_NORMAL : mode_reg;
        eff_phase = s_first_of_text ? PH_IDLE : phase_reg;
        eff_held  = s_first_of_text ? 8'h00 : held_reg;
        passes = !text_only_reg || c == 8'h09 || c == 8'h0a || c == 8'h0d ||
                 c == 8'h0c || (c >= 8'h20 && c < 8'h7f);
        mode_next  = eff_mode;
        phase_next = PH_IDLE;
        held_next  = eff_held;
        cnt   = 2'd0;
        bytes = '0;
        idle  = 1'b0;
        pair  = '0;

        unique case (eff_phase)
            PH_ESC: begin
                if (c == jsc_pkg::BYTE_DOLLAR) begin
                    phase_next = PH_ESC_DOL;
                end else if (c == jsc_pkg::BYTE_PAREN) begin
                    phase_next = PH_ESC_PAR;
                end else if (!text_only_reg) begin
                    bytes[0] = jsc_pkg::BYTE_ESC;
                    bytes[1] = c;
                    cnt = 2'd2;
                end
            end
            PH_ESC_DOL: begin
                if (c == 8'h40 || c == 8'h42) begin
                    mode_next = MODE_KANJI;
                end else if (!text_only_reg) begin
                    bytes[0] = jsc_pkg::BYTE_ESC;
                    bytes[1] = jsc_pkg::BYTE_DOLLAR;
                    bytes[2] = c;
                    cnt = 2'd3;
                end
            end
            PH_ESC_PAR: begin
                if (c == 8'h42 || c == 8'h4a) begin
                    mode_next = MODE_NORMAL;
                end else if (c == 8'h49) begin
                    mode_next = MODE_KANA;
                end else if (!text_only_reg) begin
                    bytes[0] = jsc_pkg::BYTE_ESC;
                    bytes[1] = jsc_pkg::BYTE_PAREN;
                    bytes[2] = c;
                    cnt = 2'd3;
                end
            end
            PH_JIS_HELD: begin
                if (in_jis(c)) begin
                    pair = jis_pair_convert(eff_held, c);
                    bytes[0] = pair[15:8];
                    bytes[1] = pair[7:0];
                    cnt = 2'd2;
                end else begin
                    idle = 1'b1;
                end
            end
            PH_EUC_HELD: begin
                if (in_euc(c)) begin
                    pair = jis_pair_convert({1'b0, eff_held[6:0]}, {1'b0, c[6:0]});
                    bytes[0] = pair[15:8];
                    bytes[1] = pair[7:0];
                    cnt = 2'd2;
                end else begin
                    idle = 1'b1;
                end
            end
            PH_SS2: begin
                if (in_kana(c)) begin
                    bytes[0] = c;
                    cnt = 2'd1;
                end else begin
                    idle = 1'b1;
                end
            end
            PH_SJ_HELD: begin
                // A bad trail byte drops the whole pair.
                if (sj_trail(c)) begin
                    bytes[0] = eff_held;
                    bytes[1] = c;
                    cnt = 2'd2;
                end
            end
            default: begin
                idle = 1'b1;
            end
        endcase

        if (idle) begin
            if (c == jsc_pkg::BYTE_ESC) begin
                phase_next = PH_ESC;
            end else if (c == jsc_pkg::BYTE_SO) begin
                mode_next = MODE_KANA;
            end else if (c == jsc_pkg::BYTE_SI) begin
                mode_next = MODE_NORMAL;
            end else if (eff_mode == MODE_KANJI && in_jis(c)) begin
                held_next  = c;
                phase_next = PH_JIS_HELD;
            end else if (eff_mode == MODE_KANA && c >= 8'h20 && c <= 8'h5f) begin
                bytes[0] = c | 8'h80;
                cnt = 2'd1;
            end else begin
                // A byte outside the kana range ends kana mode and is handled as normal text.
                if (eff_mode == MODE_KANA) begin
                    mode_next = MODE_NORMAL;
                end
                if (input_code_reg == jsc_pkg::CODE_EUC) begin
                    if (in_euc(c)) begin
                        held_next  = c;
                        phase_next = PH_EUC_HELD;
                    end else if (c == jsc_pkg::BYTE_SS2) begin
                        phase_next = PH_SS2;
                    end else if (passes) begin
                        bytes[0] = c;
                        cnt = 2'd1;
                    end
                end else if (passes) begin
                    bytes[0] = c;
                    cnt = 2'd1;
                end else if (sj_lead(c)) begin
                    held_next  = c;
                    phase_next = PH_SJ_HELD;
                end else if (in_kana(c)) begin
                    bytes[0] = c;
                    cnt = 2'd1;
                end
            end
        end
    end

    assign push          = accept && (cnt != 2'd0);
    assign push_run.cnt  = cnt;
    assign push_run.data = bytes;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_code_reg <= 2'd0;
            text_only_reg  <= 1'b0;
            mode_reg       <= MODE_NORMAL;
            phase_reg      <= PH_IDLE;
            held_reg       <= 8'h00;
        end else begin
            if (cfg_we) begin
                if (cfg_index == jsc_pkg::CFG_INPUT_CODE) begin
                    input_code_reg <= cfg_wdata;
                end else begin
                    text_only_reg <= cfg_wdata[0];
                end
            end
            if (accept) begin
                mode_reg  <= mode_next;
                phase_reg <= phase_next;
                held_reg  <= held_next;
            end
        end
    end

endmodule

// ===== src/jsc_queue.sv =====
// Short queue of output runs between the front end and the byte sequencer.
`timescale 1ns / 1ps

module jsc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  jsc_pkg::run_t   push_run,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output jsc_pkg::run_t   head_run
);

    jsc_pkg::run_t                 entry_reg [jsc_pkg::QDEPTH];
    logic [jsc_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [jsc_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full       = count_reg == jsc_pkg::QCNT_W'(jsc_pkg::QDEPTH);
    assign head_valid = count_reg != '0;
    assign head_run   = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("run pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("run popped from an empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= jsc_pkg::QCNT_W'(jsc_pkg::QDEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid && !full |->
            jsc_pkg::QPTR_W'(wr_ptr_reg - rd_ptr_reg) == jsc_pkg::QPTR_W'(count_reg))
        else $error("queue pointers disagree with count");

endmodule

// ===== src/jsc_back.sv =====
// Back end: sends the bytes of each queued run one per cycle while m_ready is high.
`timescale 1ns / 1ps

module jsc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  jsc_pkg::run_t   head_run,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last_of_run
);

    logic [1:0] idx_reg, idx_next;

    assign m_valid       = head_valid;
    assign m_out_byte    = head_run.data[idx_reg];
    assign m_last_of_run = idx_reg == 2'(head_run.cnt - 2'd1);
    assign pop           = m_valid && m_ready && m_last_of_run;

    always_comb begin
        idx_next = idx_reg;
        if (m_valid && m_ready) begin
            idx_next = m_last_of_run ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== src/japanese_to_shift_jis_converter.sv =====
// Top level of the ISO-2022-JP / EUC-JP to Shift_JIS byte converter.
`timescale 1ns / 1ps

// Usage:
//   Input channel s_*: one text byte per item, with s_first_of_text marking the
//   first byte of a new text (mode and any pending sequence are cleared).
//   Output channel m_*: one Shift_JIS byte per item; m_last_of_run marks the
//   final byte caused by a given input item. Input items that cause no bytes
//   (escape sequences, held lead bytes, dropped bytes) produce no output.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 input_code, 1 text_only); write only while the block is idle.
// Timing:
//   The front end takes one input item per cycle while the run queue is not full.
//   Its bytes are registered in the run queue. The output sends one byte per
//   cycle while m_ready is high, so an item that yields two or three bytes holds
//   the output longer; a four-entry run queue absorbs these bursts.
// Reset and stalls:
//   Synchronous active-low reset clears configuration, shift state and queue.
//   When m_ready is low, runs collect in the queue; once it is full s_ready drops
//   until the receiver takes the last byte of the oldest run.
module japanese_to_shift_jis_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_first_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_of_run
);

    logic          q_full;
    logic          push;
    jsc_pkg::run_t push_run;
    logic          pop;
    logic          head_valid;
    jsc_pkg::run_t head_run;

    jsc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_first_of_text (s_first_of_text),
        .q_full          (q_full),
        .push            (push),
        .push_run        (push_run)
    );

    jsc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_run   (push_run),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_run   (head_run)
    );

    jsc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_run      (head_run),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ===== dv/jsc_stream_checker.sv =====
// Testbench escape codes and the stream checker for the Shift_JIS converter.
`timescale 1ns / 1ps

package jsc_tb_pkg;

    // Final bytes of the recognized escape sequences.
    localparam logic [7:0] FIN_KANJI_AT = 8'h40;
    localparam logic [7:0] FIN_KANJI_B  = 8'h42;
    localparam logic [7:0] FIN_ASCII    = 8'h42;
    localparam logic [7:0] FIN_ROMAN    = 8'h4a;
    localparam logic [7:0] FIN_KANA     = 8'h49;

    // Input encodings other than EUC-JP; the reserved code acts as unknown.
    localparam logic [1:0] CODE_UNKNOWN  = 2'd0;
    localparam logic [1:0] CODE_SJIS     = 2'd1;
    localparam logic [1:0] CODE_RESERVED = 2'd3;

endpackage

module jsc_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_first_of_text,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_out_byte,
    input  logic        m_last_of_run,
    output int          mismatch_count,
    output int          bytes_outstanding
);

    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0a;
    localparam logic [7:0] BYTE_FF  = 8'h0c;
    localparam logic [7:0] BYTE_CR  = 8'h0d;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_KANJI,
        MODE_KANA
    } shift_mode_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_ESC_DOLLAR,
        PH_ESC_PAREN,
        PH_JIS_LEAD,
        PH_EUC_LEAD,
        PH_SS2,
        PH_SJIS_LEAD
    } seq_phase_t;

    typedef struct packed {
        logic [7:0] sjis;
        logic       last;
    } sjis_byte_t;

    sjis_byte_t  sjis_q[$];
    int          errs = 0;

    logic [1:0]  code_reg;
    logic        text_only_reg;
    shift_mode_t mode;
    seq_phase_t  phase;
    logic [7:0]  held;
    logic [7:0]  run_buf[jsc_pkg::RUN_MAX];
    int          run_len;

    function automatic bit in_jis(input logic [7:0] c);
        return c >= 8'h21 && c <= 8'h7e;
    endfunction

    function automatic bit in_euc(input logic [7:0] c);
        return c >= 8'ha1 && c <= 8'hfe;
    endfunction

    function automatic bit in_kana(input logic [7:0] c);
        return c >= 8'ha0 && c <= 8'hdf;
    endfunction

    function automatic bit sj_lead(input logic [7:0] c);
        return (c >= 8'h81 && c <= 8'h9f) || (c >= 8'he0 && c <= 8'hef);
    endfunction

    function automatic bit sj_trail(input logic [7:0] c);
        return c >= 8'h40 && c <= 8'hfc && c != 8'h7f;
    endfunction

    function automatic bit is_text(input logic [7:0] c);
        return !text_only_reg || c == BYTE_TAB || c == BYTE_LF || c == BYTE_CR ||
               c == BYTE_FF || (c >= 8'h20 && c < 8'h7f);
    endfunction

    function automatic void put(input logic [7:0] b);
        if (run_len < jsc_pkg::RUN_MAX) begin
            run_buf[run_len] = b;
            run_len++;
        end
    endfunction

    // JIS row/column pair to Shift_JIS lead and trail bytes.
    function automatic void put_jis_pair(input int h, input int l);
        int hi;
        int lo;
        if (h[0]) begin
            lo = (l < 'h60) ? l + 'h1f : l + 'h20;
        end else begin
            lo = l + 'h7e;
        end
        hi = (h < 'h5f) ? (h + 'he1) >> 1 : (h + 'h161) >> 1;
        put(hi[7:0]);
        put(lo[7:0]);
    endfunction

    // A byte seen with no sequence pending. A byte outside the kana range in
    // kana mode drops back to normal mode and is handled as a normal byte.
    function automatic void idle_byte(input logic [7:0] c);
        if (c == jsc_pkg::BYTE_ESC) begin
            phase = PH_ESC;
        end else if (c == jsc_pkg::BYTE_SO) begin
            mode = MODE_KANA;
        end else if (c == jsc_pkg::BYTE_SI) begin
            mode = MODE_NORMAL;
        end else if (mode == MODE_KANJI && in_jis(c)) begin
            held = c;
            phase = PH_JIS_LEAD;
        end else if (mode == MODE_KANA && c >= 8'h20 && c <= 8'h5f) begin
            put(c | 8'h80);
        end else begin
            if (mode == MODE_KANA) mode = MODE_NORMAL;
            if (code_reg == jsc_pkg::CODE_EUC) begin
                if (in_euc(c)) begin
                    held = c;
                    phase = PH_EUC_LEAD;
                end else if (c == jsc_pkg::BYTE_SS2) begin
                    phase = PH_SS2;
                end else if (is_text(c)) begin
                    put(c);
                end
            end else if (is_text(c)) begin
                put(c);
            end else if (sj_lead(c)) begin
                held = c;
                phase = PH_SJIS_LEAD;
            end else if (in_kana(c)) begin
                put(c);
            end
        end
    endfunction

    function automatic void predict_item(input logic [7:0] c, input logic fot);
        seq_phase_t ph;
        run_len = 0;
        if (fot) begin
            mode = MODE_NORMAL;
            phase = PH_IDLE;
            held = '0;
        end
        ph = phase;
        phase = PH_IDLE;
        case (ph)
            PH_ESC: begin
                if (c == jsc_pkg::BYTE_DOLLAR) phase = PH_ESC_DOLLAR;
                else if (c == jsc_pkg::BYTE_PAREN) phase = PH_ESC_PAREN;
                else if (!text_only_reg) begin
                    put(jsc_pkg::BYTE_ESC);
                    put(c);
                end
            end
            PH_ESC_DOLLAR: begin
                if (c == jsc_tb_pkg::FIN_KANJI_AT || c == jsc_tb_pkg::FIN_KANJI_B)
                    mode = MODE_KANJI;
                else if (!text_only_reg) begin
                    put(jsc_pkg::BYTE_ESC);
                    put(jsc_pkg::BYTE_DOLLAR);
                    put(c);
                end
            end
            PH_ESC_PAREN: begin
                if (c == jsc_tb_pkg::FIN_ASCII || c == jsc_tb_pkg::FIN_ROMAN)
                    mode = MODE_NORMAL;
                else if (c == jsc_tb_pkg::FIN_KANA) mode = MODE_KANA;
                else if (!text_only_reg) begin
                    put(jsc_pkg::BYTE_ESC);
                    put(jsc_pkg::BYTE_PAREN);
                    put(c);
                end
            end
            PH_JIS_LEAD: begin
                if (in_jis(c)) put_jis_pair(int'(held), int'(c));
                else idle_byte(c);
            end
            PH_EUC_LEAD: begin
                if (in_euc(c)) put_jis_pair(int'(held & 8'h7f), int'(c & 8'h7f));
                else idle_byte(c);
            end
            PH_SS2: begin
                if (in_kana(c)) put(c);
                else idle_byte(c);
            end
            PH_SJIS_LEAD: begin
                // A bad trail byte takes the held lead byte with it.
                if (sj_trail(c)) begin
                    put(held);
                    put(c);
                end
            end
            default: idle_byte(c);
        endcase
        for (int i = 0; i < run_len; i++) begin
            sjis_q.push_back('{sjis: run_buf[i], last: (i == run_len - 1)});
        end
    endfunction

    function automatic void report(input string what, input sjis_byte_t exp_b);
        errs++;
        if (errs <= 10) begin
            $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $realtime, what, exp_b.sjis, exp_b.last, m_out_byte, m_last_of_run);
        end
    endfunction

    always @(posedge aclk) begin
        sjis_byte_t exp_b;
        if (!aresetn) begin
            code_reg = '0;
            text_only_reg = 1'b0;
            mode = MODE_NORMAL;
            phase = PH_IDLE;
            held = '0;
            sjis_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (sjis_q.size() == 0) begin
                    report("output byte with none expected", '0);
                end else begin
                    exp_b = sjis_q.pop_front();
                    if (exp_b.sjis !== m_out_byte || exp_b.last !== m_last_of_run)
                        report("output byte mismatch", exp_b);
                end
            end
            if (s_valid && s_ready) predict_item(s_in_byte, s_first_of_text);
            if (cfg_we) begin
                if (cfg_index == jsc_pkg::CFG_INPUT_CODE) code_reg = cfg_wdata;
                else text_only_reg = cfg_wdata[0];
            end
        end
        bytes_outstanding <= sjis_q.size();
        mismatch_count <= errs;
    end

endmodule

// ===== dv/japanese_to_shift_jis_converter_tb.sv =====
// Testbench top for the Shift_JIS converter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module japanese_to_shift_jis_converter_tb;

    localparam int STALL_CYCLES = 200;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic [1:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic [7:0] s_in_byte = '0;
    logic       s_first_of_text = 1'b0;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_out_byte;
    logic       m_last_of_run;
    int         mismatch_count;
    int         bytes_outstanding;

    int         tx_idle_pct = 7;
    int         rx_idle_pct = 82;
    bit         stall_req = 1'b0;
    int         items_sent = 0;

    always #5 aclk = ~aclk;

    japanese_to_shift_jis_converter dut (.*);

    jsc_stream_checker u_checker (.*);

    // Receiver: random back-pressure, plus a long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
                stall_req = 1'b0;
            end
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic fot);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_first_of_text <= fot;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Stop sending and let every expected byte come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (bytes_outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [1:0] code, input logic txt);
        logic spare;
        spare = 1'($urandom_range(0, 1));
        cfg_we <= 1'b1;
        cfg_index <= jsc_pkg::CFG_INPUT_CODE;
        cfg_wdata <= code;
        @(posedge aclk);
        cfg_index <= jsc_pkg::CFG_TEXT_ONLY;
        cfg_wdata <= {spare, txt};
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic rare_fot();
        return $urandom_range(0, 39) == 0;
    endfunction

    function automatic logic [7:0] mostly(input int lo, input int hi);
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(lo, hi));
    endfunction

    // One short well-formed sequence with random content, or noise.
    task automatic send_random_run();
        logic [7:0] fin;
        case ($urandom_range(0, 11))
            0: send_byte(8'($urandom_range(0, 255)), rare_fot());
            1: begin
                fin = $urandom_range(0, 1) ? jsc_tb_pkg::FIN_KANJI_AT : jsc_tb_pkg::FIN_KANJI_B;
                send_byte(jsc_pkg::BYTE_ESC, rare_fot());
                send_byte(jsc_pkg::BYTE_DOLLAR, rare_fot());
                send_byte(fin, rare_fot());
            end
            2: begin
                fin = $urandom_range(0, 1) ? jsc_tb_pkg::FIN_ASCII : jsc_tb_pkg::FIN_ROMAN;
                send_byte(jsc_pkg::BYTE_ESC, rare_fot());
                send_byte(jsc_pkg::BYTE_PAREN, rare_fot());
                send_byte(fin, rare_fot());
            end
            3: begin
                send_byte(jsc_pkg::BYTE_ESC, rare_fot());
                send_byte(jsc_pkg::BYTE_PAREN, rare_fot());
                send_byte(jsc_tb_pkg::FIN_KANA, rare_fot());
            end
            4: send_byte($urandom_range(0, 1) ? jsc_pkg::BYTE_SO : jsc_pkg::BYTE_SI,
                         rare_fot());
            5, 6: begin
                send_byte(8'($urandom_range('h21, 'h7e)), rare_fot());
                send_byte(mostly('h21, 'h7e), rare_fot());
            end
            7: begin
                send_byte(8'($urandom_range('ha1, 'hfe)), rare_fot());
                send_byte(mostly('ha1, 'hfe), rare_fot());
            end
            8: begin
                send_byte(jsc_pkg::BYTE_SS2, rare_fot());
                send_byte(mostly('ha0, 'hdf), rare_fot());
            end
            9: begin
                if ($urandom_range(0, 1)) send_byte(8'($urandom_range('h81, 'h9f)), rare_fot());
                else send_byte(8'($urandom_range('he0, 'hef)), rare_fot());
                send_byte(mostly('h40, 'hfc), rare_fot());
            end
            10: begin
                if ($urandom_range(0, 1)) send_byte(8'($urandom_range('h20, 'h5f)), rare_fot());
                else send_byte(8'($urandom_range('ha0, 'hdf)), rare_fot());
            end
            default: begin
                // Escape with a random final byte.
                send_byte(jsc_pkg::BYTE_ESC, rare_fot());
                case ($urandom_range(0, 2))
                    0: ;
                    1: send_byte(jsc_pkg::BYTE_DOLLAR, rare_fot());
                    default: send_byte(jsc_pkg::BYTE_PAREN, rare_fot());
                endcase
                send_byte(8'($urandom_range(0, 255)), rare_fot());
            end
        endcase
    endtask

    task automatic run_random(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) send_random_run();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender rarely idles, receiver mostly stalls.
        set_config(jsc_tb_pkg::CODE_UNKNOWN, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(jsc_pkg::BYTE_ESC, 1'b0);
        send_byte(jsc_pkg::BYTE_DOLLAR, 1'b0);
        send_byte(jsc_tb_pkg::FIN_KANJI_B, 1'b0);
        send_byte(8'h21, 1'b0);
        send_byte(8'h21, 1'b0);
        send_byte(8'h7e, 1'b0);
        send_byte(8'h7e, 1'b0);
        // Bad second byte of a JIS pair is handled again on its own.
        send_byte(8'h30, 1'b0);
        send_byte(8'h0a, 1'b0);
        send_byte(jsc_pkg::BYTE_ESC, 1'b0);
        send_byte(jsc_pkg::BYTE_PAREN, 1'b0);
        send_byte(jsc_tb_pkg::FIN_KANA, 1'b0);
        send_byte(8'h5f, 1'b0);
        send_byte(8'h7a, 1'b0);
        wait_drained();

        set_config(jsc_pkg::CODE_EUC, 1'b1);
        send_byte(8'hb0, 1'b1);
        send_byte(8'ha1, 1'b0);
        send_byte(jsc_pkg::BYTE_SS2, 1'b0);
        send_byte(8'hb1, 1'b0);
        send_byte(jsc_pkg::BYTE_SS2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h01, 1'b0);
        wait_drained();

        set_config(jsc_tb_pkg::CODE_SJIS, 1'b1);
        send_byte(8'h88, 1'b1);
        send_byte(8'h9f, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7f, 1'b0);
        wait_drained();

        set_config(jsc_tb_pkg::CODE_UNKNOWN, 1'b0);
        run_random(70);
        wait_drained();

        // Sender mostly idles, receiver rarely stalls.
        tx_idle_pct = 82;
        rx_idle_pct = 7;
        set_config(jsc_pkg::CODE_EUC, 1'b0);
        stall_req = 1'b1;
        run_random(45);
        wait_drained();
        set_config(jsc_tb_pkg::CODE_RESERVED, 1'b1);
        run_random(45);
        wait_drained();

        // No random idling on either side; the receiver still takes one long hold-off.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_config(jsc_tb_pkg::CODE_SJIS, 1'b0);
        stall_req = 1'b1;
        run_random(25);
        wait_drained();
        run_random(20);
        wait_drained();
        set_config(jsc_pkg::CODE_EUC, 1'b1);
        run_random(45);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
